>>> hdl/lpfs_pkg.sv
// Package for the LED PWM fade sequencer: beat payload types, codes and constants.
// It has no dependencies. The top level uses it by scoped names.
package lpfs_pkg;

  localparam int PIN_W = 12;
  localparam int IDX_W = 4;

  localparam logic [7:0] LVL_MAX   = 8'd255;
  localparam logic [7:0] END_LEVEL = 8'd10;
  localparam logic [7:0] CFG_RESET = 8'd50;

  typedef enum logic [1:0] {
    FUNC_PWM   = 2'd0,
    FUNC_ANIM  = 2'd1,
    FUNC_SET   = 2'd2,
    FUNC_START = 2'd3
  } func_t;

  localparam logic [2:0] MODE_NONE    = 3'd0;
  localparam logic [2:0] MODE_ALL_UP  = 3'd1;
  localparam logic [2:0] MODE_CHAIN   = 3'd2;
  localparam logic [2:0] MODE_OVERLAP = 3'd3;
  localparam logic [2:0] MODE_ROUND   = 3'd4;
  localparam logic [2:0] MODE_ALL_DN  = 3'd5;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] level;
    logic [2:0] new_mode;
  } lpfs_in_t;

  typedef struct packed {
    logic [PIN_W-1:0] led_pins;
    logic [2:0]       mode;
    logic             anim_active;
    logic             save_request;
  } lpfs_out_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == LVL_MAX) ? v : v + 8'd1;
  endfunction

  function automatic logic [7:0] sat_dec(input logic [7:0] v);
    return (v == 8'd0) ? v : v - 8'd1;
  endfunction

endpackage

>>> hdl/led_pwm_fade_sequencer.sv
// Top level of the LED PWM fade sequencer: input register, single-pass step logic,
// result register and the configuration register. Depends on lpfs_pkg.
//
// Every accepted beat yields exactly one result beat. A beat is held in an input
// register, one pass of combinational logic applies the PWM tick, animation step,
// set-all or start to the channel state, and the result register captures the new
// pin levels and status. It takes one beat per clock while the output is not stalled;
// each beat passes the input register, then the result register, and one further beat
// can wait in the input register while the result register is stalled. cfg_ready is
// always high and the new startup level applies to beats processed after the write.
module led_pwm_fade_sequencer #(
  parameter int NUM_LEDS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpfs_pkg::lpfs_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lpfs_pkg::lpfs_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  localparam logic [4:0] NUM_C = 5'(NUM_LEDS);

  logic                in_valid_r;
  lpfs_pkg::lpfs_in_t  in_r;
  logic                out_valid_r;
  lpfs_pkg::lpfs_out_t out_r;
  lpfs_pkg::lpfs_out_t out_nxt;
  logic                advance;

  logic [7:0]                   startup_r;
  logic [7:0]                   bright_r   [NUM_LEDS];
  logic [7:0]                   bright_mid [NUM_LEDS];
  logic [7:0]                   bright_nxt [NUM_LEDS];
  logic [7:0]                   pwm_r;
  logic [7:0]                   pwm_nxt;
  logic [lpfs_pkg::IDX_W-1:0]   idx_r;
  logic [lpfs_pkg::IDX_W-1:0]   idx_nxt;
  logic [lpfs_pkg::IDX_W-1:0]   idx_rr;
  logic [2:0]                   mode_r;
  logic [2:0]                   mode_nxt;
  logic                         on_r;
  logic                         on_nxt;
  logic                         save;
  logic                         rise_end;
  logic                         idx_ok;
  logic [4:0]                   idx_inc;
  logic [4:0]                   idx_wrap;
  logic [4:0]                   idx_peer;
  logic [7:0]                   sel_cur;
  logic [7:0]                   sel_mid;
  logic [lpfs_pkg::PIN_W-1:0]   pins;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    idx_ok = ({1'b0, idx_r} < NUM_C);
    idx_inc = {1'b0, idx_r} + 5'd1;
    sel_cur = 8'd0;
    for (int k = 0; k < NUM_LEDS; k++) begin
      if (idx_r == lpfs_pkg::IDX_W'(k)) sel_cur = bright_r[k];
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_LEDS; k++) bright_mid[k] = bright_r[k];
    pwm_nxt  = pwm_r;
    idx_nxt  = idx_r;
    mode_nxt = mode_r;
    on_nxt   = on_r;
    save     = 1'b0;
    rise_end = 1'b0;
    idx_rr   = idx_ok ? idx_r : '0;
    idx_wrap = {1'b0, idx_rr} + 5'd1;
    unique case (lpfs_pkg::func_t'(in_r.func))
      lpfs_pkg::FUNC_PWM: begin
        pwm_nxt = (pwm_r == lpfs_pkg::LVL_MAX) ? 8'd1 : pwm_r + 8'd1;
      end
      lpfs_pkg::FUNC_SET: begin
        for (int k = 0; k < NUM_LEDS; k++) bright_mid[k] = in_r.level;
      end
      lpfs_pkg::FUNC_START: begin
        if (in_r.new_mode >= lpfs_pkg::MODE_ALL_UP && in_r.new_mode <= lpfs_pkg::MODE_ALL_DN) begin
          mode_nxt = in_r.new_mode;
          on_nxt   = 1'b1;
          idx_nxt  = '0;
        end
      end
      lpfs_pkg::FUNC_ANIM: begin
        if (on_r) begin
          unique case (mode_r)
            lpfs_pkg::MODE_ALL_UP: begin
              if (bright_r[0] < startup_r) begin
                for (int k = 0; k < NUM_LEDS; k++) bright_mid[k] = lpfs_pkg::sat_inc(bright_r[k]);
              end else begin
                on_nxt   = 1'b0;
                mode_nxt = lpfs_pkg::MODE_CHAIN;
                save     = 1'b1;
              end
            end
            lpfs_pkg::MODE_CHAIN, lpfs_pkg::MODE_OVERLAP: begin
              if (!idx_ok) begin
                rise_end = 1'b1;
              end else if (sel_cur < startup_r) begin
                for (int k = 0; k < NUM_LEDS; k++) begin
                  if (idx_r == lpfs_pkg::IDX_W'(k)) bright_mid[k] = bright_r[k] + 8'd1;
                end
              end else begin
                idx_nxt  = idx_inc[lpfs_pkg::IDX_W-1:0];
                rise_end = (idx_inc >= NUM_C);
              end
              if (rise_end) begin
                on_nxt   = 1'b0;
                mode_nxt = (mode_r == lpfs_pkg::MODE_CHAIN) ? lpfs_pkg::MODE_OVERLAP
                                                            : lpfs_pkg::MODE_ROUND;
                save     = 1'b1;
              end
            end
            lpfs_pkg::MODE_ROUND: begin
              for (int k = 0; k < NUM_LEDS; k++) begin
                if (idx_rr == lpfs_pkg::IDX_W'(k)) bright_mid[k] = lpfs_pkg::sat_inc(bright_r[k]);
              end
              idx_nxt = (idx_wrap >= NUM_C) ? '0 : idx_wrap[lpfs_pkg::IDX_W-1:0];
              if (bright_mid[0] >= startup_r) begin
                on_nxt   = 1'b0;
                mode_nxt = lpfs_pkg::MODE_ALL_UP;
                save     = 1'b1;
              end
            end
            lpfs_pkg::MODE_ALL_DN: begin
              for (int k = 0; k < NUM_LEDS; k++) bright_mid[k] = lpfs_pkg::sat_dec(bright_r[k]);
              if (bright_mid[0] == lpfs_pkg::END_LEVEL) begin
                on_nxt   = 1'b0;
                mode_nxt = lpfs_pkg::MODE_ALL_UP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    idx_peer = {1'b0, idx_nxt} + 5'd1;
    sel_mid = 8'd0;
    for (int k = 0; k < NUM_LEDS; k++) begin
      bright_nxt[k] = bright_mid[k];
      if (idx_nxt == lpfs_pkg::IDX_W'(k)) sel_mid = bright_mid[k];
    end
    if (in_r.func == lpfs_pkg::FUNC_ANIM && on_r && mode_r == lpfs_pkg::MODE_OVERLAP &&
        !rise_end && ({1'b0, idx_nxt} + 5'd2 < NUM_C) && sel_mid > (startup_r >> 1)) begin
      for (int k = 0; k < NUM_LEDS; k++) begin
        if (idx_peer == 5'(k)) bright_nxt[k] = lpfs_pkg::sat_inc(bright_mid[k]);
      end
    end
  end

  always_comb begin
    pins = '0;
    for (int k = 0; k < lpfs_pkg::PIN_W; k++) begin
      if (k < NUM_LEDS) begin
        pins[k] = (pwm_nxt != 8'd0) && (bright_nxt[k] >= pwm_nxt);
      end
    end
    out_nxt.led_pins     = pins;
    out_nxt.mode         = mode_nxt;
    out_nxt.anim_active  = on_nxt;
    out_nxt.save_request = save;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      startup_r   <= lpfs_pkg::CFG_RESET;
      pwm_r       <= 8'd0;
      idx_r       <= '0;
      mode_r      <= lpfs_pkg::MODE_NONE;
      on_r        <= 1'b0;
      for (int k = 0; k < NUM_LEDS; k++) bright_r[k] <= 8'd0;
    end else begin
      if (cfg_valid && cfg_ready) startup_r <= cfg_data;
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        pwm_r  <= pwm_nxt;
        idx_r  <= idx_nxt;
        mode_r <= mode_nxt;
        on_r   <= on_nxt;
        for (int k = 0; k < NUM_LEDS; k++) bright_r[k] <= bright_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_data;
    if (advance) out_r <= out_nxt;
  end

  a_save_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.save_request |-> !out_r.anim_active)
    else $error("save request while animation still active");

  a_on_mode: assert property (@(posedge clk) disable iff (!rst_n)
    on_r |-> (mode_r >= lpfs_pkg::MODE_ALL_UP && mode_r <= lpfs_pkg::MODE_ALL_DN))
    else $error("animation active in a mode with no meaning");

  a_pwm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    pwm_r != 8'd0 |=> pwm_r != 8'd0)
    else $error("pwm counter returned to zero");

  a_skid_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ready)
    else $error("input not ready with empty input register");

endmodule
